// ===== hdl/sorted_priority_queue_unit_assert.svh =====
// Assertion macros shared by the sorted priority queue checker.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

// ===== hdl/spq_pkg.sv =====
// Package of the sorted priority queue: operation and status codes, command struct.
// Used by the cell, the top level and the checker; depends on nothing.
package spq_pkg;

    localparam int PRIO_BITS = 32;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                        enq;
        logic                        deq;
        logic signed [PRIO_BITS-1:0] prio;
    } spq_cmd_t;

endpackage

// ===== hdl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: a row of spq_cell slots plus a result register.
// Depends on spq_pkg and spq_cell.
//
//   channel  valid      stall      payload
//   request  in_valid   in_stall   func, tag, prio
//   result   out_valid  out_stall  status, out_tag, out_prio, occupancy, is_empty
//
// Every request finishes in the cycle it is accepted: all slots compare against the
// new priority in parallel and shift one place, so one request is taken per cycle while in_stall is low.
// The result sits in the output register from the next cycle until it is taken.
// The request side stalls only while a result is held and out_stall is high.
// Reset empties the queue at once; slot contents are not cleared.
module sorted_priority_queue_unit #(
    parameter int  DEPTH    = 16,
    parameter int  TAG_BITS = 32,
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic [TAG_BITS-1:0]                  tag,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] prio,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [TAG_BITS-1:0]                  out_tag,
    output logic signed [spq_pkg::PRIO_BITS-1:0] out_prio,
    output logic [CNT_W-1:0]                     occupancy,
    output logic                                 is_empty
);

    logic                                 accept;
    logic                                 full;
    logic                                 empty;
    spq_pkg::spq_cmd_t                    cmd;
    logic [CNT_W-1:0]                     count_reg;
    logic [CNT_W-1:0]                     count_next;
    logic [DEPTH-1:0]                     cell_after;
    logic [TAG_BITS-1:0]                  cell_tag  [DEPTH];
    logic signed [spq_pkg::PRIO_BITS-1:0] cell_prio [DEPTH];

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [1:0]                           status_reg;
    logic [1:0]                           status_next;
    logic [TAG_BITS-1:0]                  out_tag_reg;
    logic [TAG_BITS-1:0]                  out_tag_next;
    logic signed [spq_pkg::PRIO_BITS-1:0] out_prio_reg;
    logic signed [spq_pkg::PRIO_BITS-1:0] out_prio_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;

    always_comb
    begin
        cmd.enq  = accept && (func == spq_pkg::FUNC_ENQ) && !full;
        cmd.deq  = accept && (func == spq_pkg::FUNC_DEQ) && !empty;
        cmd.prio = prio;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic                                 l_after;
            logic [TAG_BITS-1:0]                  l_tag;
            logic signed [spq_pkg::PRIO_BITS-1:0] l_prio;
            logic [TAG_BITS-1:0]                  r_tag;
            logic signed [spq_pkg::PRIO_BITS-1:0] r_prio;

            if (i == 0) begin : g_left_edge
                assign l_after = 1'b1;
                assign l_tag   = tag;
                assign l_prio  = prio;
            end else begin : g_left
                assign l_after = cell_after[i-1];
                assign l_tag   = cell_tag[i-1];
                assign l_prio  = cell_prio[i-1];
            end

            if (i == DEPTH - 1) begin : g_right_edge
                assign r_tag  = cell_tag[i];
                assign r_prio = cell_prio[i];
            end else begin : g_right
                assign r_tag  = cell_tag[i+1];
                assign r_prio = cell_prio[i+1];
            end

            spq_cell #(
                .TAG_BITS (TAG_BITS),
                .CNT_W    (CNT_W),
                .IDX      (i)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .new_tag    (tag),
                .count      (count_reg),
                .left_after (l_after),
                .left_tag   (l_tag),
                .left_prio  (l_prio),
                .right_tag  (r_tag),
                .right_prio (r_prio),
                .after      (cell_after[i]),
                .tag_q      (cell_tag[i]),
                .prio_q     (cell_prio[i])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = accept || (out_valid_reg && out_stall);
        status_next    = spq_pkg::STATUS_OK;
        out_tag_next   = '0;
        out_prio_next  = '0;
        if (func == spq_pkg::FUNC_ENQ)
        begin
            if (full)
            begin
                status_next = spq_pkg::STATUS_FULL;
            end
        end
        else if (empty)
        begin
            status_next = spq_pkg::STATUS_EMPTY;
        end
        else
        begin
            out_tag_next  = cell_tag[0];
            out_prio_next = cell_prio[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            out_tag_reg  <= out_tag_next;
            out_prio_reg <= out_prio_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_tag   = out_tag_reg;
    assign out_prio  = out_prio_reg;
    assign occupancy = count_reg;
    assign is_empty  = count_reg == '0;

endmodule

// ===== hdl/spq_cell.sv =====
// One slot of the sorted shift row: holds one entry and trades it with its neighbors.
// Depends on spq_pkg for the command struct.
module spq_cell #(
    parameter int TAG_BITS = 32,
    parameter int CNT_W    = 5,
    parameter int IDX      = 0
) (
    input  logic                                clk,
    input  spq_pkg::spq_cmd_t                   cmd,
    input  logic [TAG_BITS-1:0]                 new_tag,
    input  logic [CNT_W-1:0]                    count,
    input  logic                                left_after,
    input  logic [TAG_BITS-1:0]                 left_tag,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] left_prio,
    input  logic [TAG_BITS-1:0]                 right_tag,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] right_prio,
    output logic                                after,
    output logic [TAG_BITS-1:0]                 tag_q,
    output logic signed [spq_pkg::PRIO_BITS-1:0] prio_q
);

    logic [TAG_BITS-1:0]                  tag_reg;
    logic [TAG_BITS-1:0]                  tag_next;
    logic signed [spq_pkg::PRIO_BITS-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_BITS-1:0] prio_next;
    logic                                 held;

    assign held = count > CNT_W'(IDX);

    // The front slot keeps its place on a tie; every later slot yields on a tie.
    generate
        if (IDX == 0) begin : g_front
            assign after = held && !(prio_reg < cmd.prio);
        end else begin : g_rest
            assign after = held && (prio_reg > cmd.prio);
        end
    endgenerate

    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (cmd.enq && !after)
        begin
            if (left_after)
            begin
                tag_next  = new_tag;
                prio_next = cmd.prio;
            end
            else
            begin
                tag_next  = left_tag;
                prio_next = left_prio;
            end
        end
        else if (cmd.deq)
        begin
            tag_next  = right_tag;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign tag_q  = tag_reg;
    assign prio_q = prio_reg;

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and the assertion macros in sorted_priority_queue_unit_assert.svh.
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker #(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 32,
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [1:0]                           status,
    input logic [TAG_BITS-1:0]                  out_tag,
    input logic signed [spq_pkg::PRIO_BITS-1:0] out_prio,
    input logic [CNT_W-1:0]                     occupancy,
    input logic                                 is_empty
);

    `SPQ_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(out_tag) && $stable(out_prio))
    `SPQ_ASSERT_SAME(a_empty_flag, clk, rst_n, out_valid, is_empty == (occupancy == '0))
    `SPQ_ASSERT_SAME(a_reject_zero, clk, rst_n, out_valid && (status != spq_pkg::STATUS_OK), (out_tag == '0) && (out_prio == '0))
    `SPQ_ASSERT_SAME(a_full_count, clk, rst_n, out_valid && (status == spq_pkg::STATUS_FULL), occupancy == CNT_W'(DEPTH))
    `SPQ_ASSERT_SAME(a_empty_reject, clk, rst_n, out_valid && (status == spq_pkg::STATUS_EMPTY), is_empty)

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .CNT_W    (CNT_W)
) u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_tag   (out_tag),
    .out_prio  (out_prio),
    .occupancy (occupancy),
    .is_empty  (is_empty)
);
